>>> hdl/sdo_expedited_client_core_macros.svh
// Assertion macros shared by the SDO client modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef SDO_EXPEDITED_CLIENT_CORE_MACROS_SVH
`define SDO_EXPEDITED_CLIENT_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define SDO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define SDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sdo_pkg.sv
// Shared types and constants of the expedited SDO client.
// Used by the front, queue, back and top level modules; depends on nothing.
package sdo_pkg;

    // Input modes
    localparam logic [2:0] MODE_WRITE        = 3'd0;
    localparam logic [2:0] MODE_READ         = 3'd1;
    localparam logic [2:0] MODE_WRITE_NOWAIT = 3'd2;
    localparam logic [2:0] MODE_FRAME        = 3'd3;
    localparam logic [2:0] MODE_TICK         = 3'd4;

    // Classified item kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CMD   = 2'd0;
    localparam t_kind KIND_FRAME = 2'd1;
    localparam t_kind KIND_TICK  = 2'd2;

    // Result kinds and status codes
    localparam logic       RESULT_FRAME   = 1'b0;
    localparam logic       RESULT_DONE    = 1'b1;
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ERROR   = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
    localparam logic [1:0] STATUS_BUSY    = 2'd3;

    // Configuration register indexes
    localparam logic REG_ATTEMPTS = 1'b0;
    localparam logic REG_RETRY    = 1'b1;
    localparam logic [7:0] ATTEMPTS_RESET = 8'd15;
    localparam logic       RETRY_RESET    = 1'b1;

    // Command bytes
    localparam logic [7:0] CMD_WRITE_BASE = 8'h20;
    localparam logic [7:0] CMD_READ_BASE  = 8'h40;
    localparam logic [7:0] SIZE_CODE_1    = 8'h0F;
    localparam logic [7:0] SIZE_CODE_2    = 8'h0B;
    localparam logic [7:0] SIZE_CODE_3    = 8'h07;
    localparam logic [7:0] SIZE_CODE_4    = 8'h03;
    localparam logic [7:0] REPLY_WRITE_OK = 8'h60;
    localparam logic [3:0] REPLY_READ_HI  = 4'h4;
    localparam logic [7:0] REPLY_READ_1   = 8'h4F;
    localparam logic [7:0] REPLY_READ_2   = 8'h4B;
    localparam logic [7:0] REPLY_READ_3   = 8'h47;
    localparam logic [7:0] REPLY_READ_4   = 8'h43;

    // Upper four identifier bits: 0x600 request, 0x580 response
    localparam logic [3:0] REQ_ID_HI = 4'hC;
    localparam logic [3:0] RSP_ID_HI = 4'hB;
    localparam logic [3:0] MIN_REPLY_LEN = 4'd4;
    localparam logic [2:0] MAX_DATA_SIZE = 3'd4;

    typedef struct packed {
        t_kind       kind;
        logic        wait_reply;  // command that waits for a reply
        logic        is_read;
        logic [6:0]  node;        // command node or reply node from the id
        logic [15:0] index;
        logic [7:0]  sub;
        logic [63:0] data;        // request bytes, or decoded read value
        logic        reply_ok;    // response id range and length are fine
        logic        wr_ok;
        logic        rd_ok;
        logic [2:0]  rd_size;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [10:0] tx_id;
        logic [63:0] tx_bytes;
        logic [1:0]  status;
        logic [2:0]  read_size;
        logic [31:0] read_value;
    } t_result;

endpackage

>>> hdl/sdo_front.sv
// Front end: classifies incoming items and builds request and reply fields.
// Depends on sdo_pkg; feeds sdo_queue.
module sdo_front
    import sdo_pkg::*;
(
    input  logic        i_valid,
    input  logic        i_queue_full,
    input  logic [2:0]  i_mode,
    input  logic [6:0]  i_node_id,
    input  logic [15:0] i_obj_index,
    input  logic [7:0]  i_obj_subindex,
    input  logic [2:0]  i_data_size,
    input  logic [31:0] i_data_value,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_dlc,
    input  logic [63:0] i_frame_bytes,
    output logic        o_ready,
    output logic        o_push,
    output t_item       o_item
);

    logic [2:0]  w_size;
    logic [7:0]  w_code;
    logic [7:0]  w_cmd;
    logic [31:0] w_req_data;
    logic [7:0]  w_reply_cmd;
    logic [2:0]  w_rd_size;
    logic [31:0] w_rd_value;
    logic        w_known;
    logic        w_is_cmd;

    assign w_size = (i_data_size > MAX_DATA_SIZE) ? MAX_DATA_SIZE : i_data_size;

    always_comb begin
        unique case (w_size)
            3'd1:    w_code = SIZE_CODE_1;
            3'd2:    w_code = SIZE_CODE_2;
            3'd3:    w_code = SIZE_CODE_3;
            3'd4:    w_code = SIZE_CODE_4;
            default: w_code = 8'h00;
        endcase
    end

    assign w_cmd = ((i_mode == MODE_READ) ? CMD_READ_BASE : CMD_WRITE_BASE) + w_code;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_req_data[8*k +: 8] = (3'(k) < w_size) ? i_data_value[8*k +: 8] : 8'h00;
        end
    end

    // Reply decoding is stateless, so it is done here; matching happens later.
    assign w_reply_cmd = i_frame_bytes[7:0];

    always_comb begin
        unique case (w_reply_cmd)
            REPLY_READ_1: w_rd_size = 3'd1;
            REPLY_READ_2: w_rd_size = 3'd2;
            REPLY_READ_3: w_rd_size = 3'd3;
            REPLY_READ_4: w_rd_size = 3'd4;
            default:      w_rd_size = 3'd0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_rd_value[8*k +: 8] = (3'(k) < w_rd_size) ? i_frame_bytes[32 + 8*k +: 8] : 8'h00;
        end
    end

    assign w_is_cmd = (i_mode == MODE_WRITE) || (i_mode == MODE_READ) ||
                      (i_mode == MODE_WRITE_NOWAIT);
    assign w_known  = w_is_cmd || (i_mode == MODE_FRAME) || (i_mode == MODE_TICK);

    assign o_ready = !i_queue_full;
    // Unused modes are taken and dropped here.
    assign o_push  = i_valid && !i_queue_full && w_known;

    always_comb begin
        o_item = '0;
        if (w_is_cmd) begin
            o_item.kind       = KIND_CMD;
            o_item.wait_reply = (i_mode != MODE_WRITE_NOWAIT);
            o_item.is_read    = (i_mode == MODE_READ);
            o_item.node       = i_node_id;
            o_item.index      = i_obj_index;
            o_item.sub        = i_obj_subindex;
            o_item.data       = {w_req_data, i_obj_subindex, i_obj_index, w_cmd};
        end else begin
            o_item.kind     = (i_mode == MODE_FRAME) ? KIND_FRAME : KIND_TICK;
            o_item.node     = i_frame_id[6:0];
            o_item.index    = i_frame_bytes[23:8];
            o_item.sub      = i_frame_bytes[31:24];
            o_item.data     = {32'h0, w_rd_value};
            o_item.reply_ok = (i_frame_id[10:7] == RSP_ID_HI) &&
                              (i_frame_dlc >= MIN_REPLY_LEN);
            o_item.wr_ok    = (w_reply_cmd == REPLY_WRITE_OK);
            o_item.rd_ok    = (w_reply_cmd[7:4] == REPLY_READ_HI);
            o_item.rd_size  = w_rd_size;
        end
    end

endmodule

>>> hdl/sdo_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on sdo_pkg and the assertion macro header.
`include "sdo_expedited_client_core_macros.svh"
module sdo_queue
    import sdo_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_item r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `SDO_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `SDO_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

>>> hdl/sdo_back.sv
// Back end: transfer state, reply matching, attempt counting and result register.
// Depends on sdo_pkg and the assertion macro header; drains sdo_queue.
`include "sdo_expedited_client_core_macros.svh"
module sdo_back
    import sdo_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_empty,
    input  t_item      i_head,
    output logic       o_pop,
    output logic       o_valid,
    output t_result    o_result,
    input  logic       i_ready
);

    logic [7:0]  r_attempts_cfg;
    logic        r_retry_en;

    logic        r_busy, n_busy;
    logic        r_is_read, n_is_read;
    logic [6:0]  r_node, n_node;
    logic [15:0] r_index, n_index;
    logic [7:0]  r_sub, n_sub;
    logic [7:0]  r_attempts_left, n_attempts_left;
    logic        r_already_resent, n_already_resent;
    logic [63:0] r_saved_request, n_saved_request;

    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        w_res_valid;
    t_result     w_res;
    logic [7:0]  w_load;
    logic [7:0]  w_dec;
    logic        w_match;

    // The next item moves on when the result register is free or being drained.
    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    assign w_load  = (r_attempts_cfg == 8'd0) ? 8'd1 : r_attempts_cfg;
    assign w_dec   = (r_attempts_left != 8'd0) ? r_attempts_left - 8'd1 : r_attempts_left;
    assign w_match = (i_head.kind == KIND_FRAME) && i_head.reply_ok &&
                     (i_head.node == r_node) && (i_head.index == r_index) &&
                     (i_head.sub == r_sub);

    always_comb begin
        n_busy           = r_busy;
        n_is_read        = r_is_read;
        n_node           = r_node;
        n_index          = r_index;
        n_sub            = r_sub;
        n_attempts_left  = r_attempts_left;
        n_already_resent = r_already_resent;
        n_saved_request  = r_saved_request;
        w_res_valid      = 1'b0;
        w_res            = '0;
        if (o_pop) begin
            unique case (i_head.kind) inside
                KIND_CMD: begin
                    w_res_valid = 1'b1;
                    if (r_busy) begin
                        w_res.kind   = RESULT_DONE;
                        w_res.status = STATUS_BUSY;
                    end else begin
                        w_res.kind     = RESULT_FRAME;
                        w_res.tx_id    = {REQ_ID_HI, i_head.node};
                        w_res.tx_bytes = i_head.data;
                        if (i_head.wait_reply) begin
                            n_busy           = 1'b1;
                            n_is_read        = i_head.is_read;
                            n_node           = i_head.node;
                            n_index          = i_head.index;
                            n_sub            = i_head.sub;
                            n_attempts_left  = w_load;
                            n_already_resent = 1'b0;
                            n_saved_request  = i_head.data;
                        end
                    end
                end
                KIND_FRAME, KIND_TICK: begin
                    if (r_busy && w_match) begin
                        n_busy      = 1'b0;
                        w_res_valid = 1'b1;
                        w_res.kind  = RESULT_DONE;
                        if (!r_is_read) begin
                            w_res.status = i_head.wr_ok ? STATUS_OK : STATUS_ERROR;
                        end else if (i_head.rd_ok) begin
                            w_res.status     = STATUS_OK;
                            w_res.read_size  = i_head.rd_size;
                            w_res.read_value = i_head.data[31:0];
                        end else begin
                            w_res.status = STATUS_ERROR;
                        end
                    end else if (r_busy) begin
                        n_attempts_left = w_dec;
                        if (w_dec == 8'd0) begin
                            w_res_valid = 1'b1;
                            if (!r_is_read && r_retry_en && !r_already_resent) begin
                                n_already_resent = 1'b1;
                                n_attempts_left  = w_load;
                                w_res.kind       = RESULT_FRAME;
                                w_res.tx_id      = {REQ_ID_HI, r_node};
                                w_res.tx_bytes   = r_saved_request;
                            end else begin
                                n_busy       = 1'b0;
                                w_res.kind   = RESULT_DONE;
                                w_res.status = STATUS_TIMEOUT;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (!r_out_valid || i_ready) begin
            n_out_valid = w_res_valid;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attempts_cfg   <= ATTEMPTS_RESET;
            r_retry_en       <= RETRY_RESET;
            r_busy           <= 1'b0;
            r_is_read        <= 1'b0;
            r_node           <= '0;
            r_index          <= '0;
            r_sub            <= '0;
            r_attempts_left  <= '0;
            r_already_resent <= 1'b0;
            r_saved_request  <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en && i_cfg_addr == REG_ATTEMPTS) begin
                r_attempts_cfg <= i_cfg_wdata;
            end
            if (i_cfg_wr_en && i_cfg_addr == REG_RETRY) begin
                r_retry_en <= i_cfg_wdata[0];
            end
            r_busy           <= n_busy;
            r_is_read        <= n_is_read;
            r_node           <= n_node;
            r_index          <= n_index;
            r_sub            <= n_sub;
            r_attempts_left  <= n_attempts_left;
            r_already_resent <= n_already_resent;
            r_saved_request  <= n_saved_request;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `SDO_ASSERT_NOW(a_busy_has_attempts, i_clk, i_rst_n, r_busy, r_attempts_left != 8'd0, "busy with no attempts left")
    `SDO_ASSERT_NOW(a_resend_only_write, i_clk, i_rst_n, r_busy && r_already_resent, !r_is_read, "read marked as resent")
    `SDO_ASSERT_NEXT(a_busy_cmd_keeps, i_clk, i_rst_n, o_pop && i_head.kind == KIND_CMD && r_busy, r_busy, "busy command ended transfer")

endmodule

>>> hdl/sdo_expedited_client_core.sv
// Expedited CANopen SDO client: in the slave stream go commands, received
// frames and ticks; out of the master stream come request frames to send and
// transfer completions. Mode travels in tuser, the remaining fields in tdata.
// The config port sets attempts_per_send (index 0) and write_retry_enable
// (index 1); write it only while no transfer is in progress.
// An accepted item is written into the item queue; once it reaches the head
// and is popped, the back end registers its result in the result register.
// Throughput: one item per cycle, no-result items included, set by the back
// end that drains the queue while the result register is free or draining.
// When the receiver stalls, the result register holds and the queue absorbs
// up to QUEUE_DEPTH further items before s_axis_tready drops.
// Reset (synchronous, active low) clears the queue, the pending transfer and
// the result register and restores the register defaults (15 attempts,
// write resend enabled).
// Depends on sdo_pkg, sdo_front, sdo_queue and sdo_back.
module sdo_expedited_client_core
    import sdo_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: node_id, obj_index, obj_subindex, data_size, data_value,
    //        frame_id, frame_dlc, frame_bytes, zero fill
    input  logic [151:0] i_s_axis_tdata,
    // tuser: mode
    input  logic [2:0]   i_s_axis_tuser,
    // Master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: tx_id, tx_bytes, status, read_size, read_value
    output logic [111:0] o_m_axis_tdata,
    // tuser: result_kind
    output logic         o_m_axis_tuser,
    // Configuration write port
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_addr,
    input  logic [7:0]   i_cfg_wdata
);

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_item   w_item;
    t_item   w_head;
    t_result w_result;

    sdo_front u_front (
        .i_valid        (i_s_axis_tvalid),
        .i_queue_full   (w_full),
        .i_mode         (i_s_axis_tuser),
        .i_node_id      (i_s_axis_tdata[6:0]),
        .i_obj_index    (i_s_axis_tdata[22:7]),
        .i_obj_subindex (i_s_axis_tdata[30:23]),
        .i_data_size    (i_s_axis_tdata[33:31]),
        .i_data_value   (i_s_axis_tdata[65:34]),
        .i_frame_id     (i_s_axis_tdata[76:66]),
        .i_frame_dlc    (i_s_axis_tdata[80:77]),
        .i_frame_bytes  (i_s_axis_tdata[144:81]),
        .o_ready        (o_s_axis_tready),
        .o_push         (w_push),
        .o_item         (w_item)
    );

    sdo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sdo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .o_result    (w_result),
        .i_ready     (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {w_result.read_value, w_result.read_size, w_result.status,
                             w_result.tx_bytes, w_result.tx_id};
    assign o_m_axis_tuser = w_result.kind;

endmodule
